// ===== sv/dual_rc4_stream_cipher_top_assert.svh =====
// Assertion macros for the dual RC4 stream cipher top level.
`ifndef DUAL_RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define DUAL_RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define DRC4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define DRC4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/drc4_pkg.sv =====
// Shared types, codes and helpers of the dual RC4 stream cipher.
`default_nettype none
package drc4_pkg;

  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int KEY_BITS      = 8 * MAX_KEY_BYTES;

  typedef logic [7:0]           byte_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [4:0]           key_len_t;
  typedef logic [2:0]           cfg_idx_t;
  typedef logic [1:0]           mode_t;

  // Item modes
  localparam mode_t MODE_ENC   = 2'd0;
  localparam mode_t MODE_DEC   = 2'd1;
  localparam mode_t MODE_REKEY = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t REG_ENC_KEY_LO = 3'd0;
  localparam cfg_idx_t REG_ENC_KEY_HI = 3'd1;
  localparam cfg_idx_t REG_DEC_KEY_LO = 3'd2;
  localparam cfg_idx_t REG_DEC_KEY_HI = 3'd3;
  localparam cfg_idx_t REG_ENC_KEY_LEN = 3'd4;
  localparam cfg_idx_t REG_DEC_KEY_LEN = 3'd5;

  // Index of the last key byte in use: zero length acts as one, long lengths saturate.
  function automatic key_idx_t key_last(input key_len_t len);
    key_idx_t r;
    if (len == 5'd0) begin
      r = '0;
    end else if (int'(len) > MAX_KEY_BYTES) begin
      r = key_idx_t'(MAX_KEY_BYTES - 1);
    end else begin
      r = key_idx_t'(len - 5'd1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dual_rc4_stream_cipher_top.sv =====
// Dual RC4 stream cipher top level: two permutation memories and their sequencer.
`default_nettype none
`include "dual_rc4_stream_cipher_top_assert.svh"
// Two RC4 generators, encrypt and decrypt, each with its 256 x 8 permutation in a
// synchronous RAM (one read, one write per cycle, registered read data). Mode 0
// and 1 items XOR one keystream byte of the chosen stream into data_in; a byte
// item reads S[i], then S[j], then writes the swap, issuing the read of
// S[S[i]+S[j]] alongside the first swap write, before its result goes to the
// output register. No new item is taken until the last one has been handed to
// the output register. A rekey item (mode 2) fills both permutations with the
// identity and runs the key schedule on both in parallel, one entry after another
// (read, accumulate, then the swap writes, for each entry). Before the first
// rekey, byte items pass through and touch no state. Mode 3 returns zero.
// Write configuration only while the block is idle; cfg_ready_o is always high.
module dual_rc4_stream_cipher_top (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // Configuration write channel
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire drc4_pkg::cfg_idx_t cfg_index_i,
  input  wire [63:0]              cfg_data_i,
  // Input item channel
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  wire [1:0]               mode_i,
  input  wire [7:0]               data_in_i,
  input  wire                     last_in_message_i,
  // Result item channel
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output logic [7:0]              data_out_o,
  output logic                    was_keyed_o,
  output logic                    last_out_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILL  = 4'd1;
  localparam logic [3:0] ST_K_RD  = 4'd2;
  localparam logic [3:0] ST_K_ACC = 4'd3;
  localparam logic [3:0] ST_K_W1  = 4'd4;
  localparam logic [3:0] ST_K_W2  = 4'd5;
  localparam logic [3:0] ST_P_RD1 = 4'd6;
  localparam logic [3:0] ST_P_RD2 = 4'd7;
  localparam logic [3:0] ST_P_W1  = 4'd8;
  localparam logic [3:0] ST_P_W2  = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // Configuration registers
  logic [63:0]        enc_key_lo_q, enc_key_hi_q, dec_key_lo_q, dec_key_hi_q;
  drc4_pkg::key_len_t enc_key_len_q, dec_key_len_q;

  // Control state
  logic [3:0]  state_q, state_d;
  logic        keyed_q, keyed_d;
  drc4_pkg::byte_t ii_q [2];
  drc4_pkg::byte_t ii_d [2];
  drc4_pkg::byte_t jj_q [2];
  drc4_pkg::byte_t jj_d [2];
  logic        out_valid_q, out_valid_d;

  // Item and work registers
  drc4_pkg::mode_t mode_q, mode_d;
  drc4_pkg::byte_t data_q, data_d;
  logic            last_q, last_d;
  logic            was_q, was_d;
  drc4_pkg::byte_t res_q, res_d;
  drc4_pkg::byte_t k_q, k_d;
  drc4_pkg::byte_t acc_q [2];
  drc4_pkg::byte_t acc_d [2];
  drc4_pkg::byte_t sk_q [2];
  drc4_pkg::byte_t sk_d [2];
  drc4_pkg::key_idx_t kidx_q [2];
  drc4_pkg::key_idx_t kidx_d [2];
  drc4_pkg::byte_t ni_q, ni_d, nj_q, nj_d, a_q, a_d, b_q, b_d;
  logic            fwd_i_q, fwd_i_d, fwd_j_q, fwd_j_d;
  drc4_pkg::byte_t dout_q, dout_d;
  logic            wkd_out_q, wkd_out_d, lst_out_q, lst_out_d;

  // Permutation memories: index 0 encrypt, index 1 decrypt
  drc4_pkg::byte_t enc_sbox [256];
  drc4_pkg::byte_t dec_sbox [256];
  drc4_pkg::byte_t sbox_raddr [2];
  drc4_pkg::byte_t sbox_waddr [2];
  drc4_pkg::byte_t sbox_wdata [2];
  logic            sbox_we    [2];
  drc4_pkg::byte_t sbox_rd_q  [2];

  logic [drc4_pkg::KEY_BITS-1:0] key_all [2];
  drc4_pkg::key_idx_t key_lst [2];
  drc4_pkg::byte_t    key_byte [2];
  drc4_pkg::byte_t    ksa_sum [2];
  drc4_pkg::byte_t    tidx;
  drc4_pkg::byte_t    kstream;
  logic               sel;
  logic               out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign data_out_o  = dout_q;
  assign was_keyed_o = wkd_out_q;
  assign last_out_o  = lst_out_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign sel      = (mode_q == drc4_pkg::MODE_DEC);

  assign key_all[0] = {enc_key_hi_q, enc_key_lo_q};
  assign key_all[1] = {dec_key_hi_q, dec_key_lo_q};
  assign key_lst[0] = drc4_pkg::key_last(enc_key_len_q);
  assign key_lst[1] = drc4_pkg::key_last(dec_key_len_q);

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      key_byte[s] = key_all[s][{kidx_q[s], 3'b000} +: 8];
      ksa_sum[s]  = acc_q[s] + sbox_rd_q[s] + key_byte[s];
    end
  end

  assign tidx    = a_q + sbox_rd_q[sel];
  // New S[j] holds a, new S[i] holds b; the memory holds the rest.
  assign kstream = fwd_j_q ? a_q : (fwd_i_q ? b_q : sbox_rd_q[sel]);

  always_ff @(posedge clk_i) begin
    if (sbox_we[0]) begin
      enc_sbox[sbox_waddr[0]] <= sbox_wdata[0];
    end
    sbox_rd_q[0] <= enc_sbox[sbox_raddr[0]];
  end

  always_ff @(posedge clk_i) begin
    if (sbox_we[1]) begin
      dec_sbox[sbox_waddr[1]] <= sbox_wdata[1];
    end
    sbox_rd_q[1] <= dec_sbox[sbox_raddr[1]];
  end

  always_comb begin
    state_d     = state_q;
    keyed_d     = keyed_q;
    out_valid_d = out_valid_q && out_stall_i;
    mode_d      = mode_q;
    data_d      = data_q;
    last_d      = last_q;
    was_d       = was_q;
    res_d       = res_q;
    k_d         = k_q;
    ni_d        = ni_q;
    nj_d        = nj_q;
    a_d         = a_q;
    b_d         = b_q;
    fwd_i_d     = fwd_i_q;
    fwd_j_d     = fwd_j_q;
    dout_d      = dout_q;
    wkd_out_d   = wkd_out_q;
    lst_out_d   = lst_out_q;
    for (int s = 0; s < 2; s++) begin
      ii_d[s]       = ii_q[s];
      jj_d[s]       = jj_q[s];
      acc_d[s]      = acc_q[s];
      sk_d[s]       = sk_q[s];
      kidx_d[s]     = kidx_q[s];
      sbox_raddr[s] = '0;
      sbox_waddr[s] = '0;
      sbox_wdata[s] = '0;
      sbox_we[s]    = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_i;
          data_d = data_in_i;
          last_d = last_in_message_i;
          was_d  = keyed_q;
          case (mode_i)
            drc4_pkg::MODE_ENC, drc4_pkg::MODE_DEC: begin
              if (keyed_q) begin
                state_d = ST_P_RD1;
              end else begin
                res_d   = data_in_i;
                state_d = ST_DONE;
              end
            end
            drc4_pkg::MODE_REKEY: begin
              k_d = '0;
              for (int s = 0; s < 2; s++) begin
                acc_d[s]  = '0;
                kidx_d[s] = '0;
              end
              state_d = ST_FILL;
            end
            default: begin
              res_d   = '0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_FILL: begin
        for (int s = 0; s < 2; s++) begin
          sbox_we[s]    = 1'b1;
          sbox_waddr[s] = k_q;
          sbox_wdata[s] = k_q;
        end
        k_d = k_q + 8'd1;
        if (k_q == 8'hFF) begin
          state_d = ST_K_RD;
        end
      end
      ST_K_RD: begin
        for (int s = 0; s < 2; s++) begin
          sbox_raddr[s] = k_q;
        end
        state_d = ST_K_ACC;
      end
      ST_K_ACC: begin
        for (int s = 0; s < 2; s++) begin
          acc_d[s]      = ksa_sum[s];
          sbox_raddr[s] = ksa_sum[s];
          sk_d[s]       = sbox_rd_q[s];
          kidx_d[s]     = (kidx_q[s] == key_lst[s]) ? '0 : kidx_q[s] + 1'b1;
        end
        state_d = ST_K_W1;
      end
      ST_K_W1: begin
        for (int s = 0; s < 2; s++) begin
          sbox_we[s]    = 1'b1;
          sbox_waddr[s] = k_q;
          sbox_wdata[s] = sbox_rd_q[s];
        end
        state_d = ST_K_W2;
      end
      ST_K_W2: begin
        for (int s = 0; s < 2; s++) begin
          sbox_we[s]    = 1'b1;
          sbox_waddr[s] = acc_q[s];
          sbox_wdata[s] = sk_q[s];
        end
        k_d = k_q + 8'd1;
        if (k_q == 8'hFF) begin
          keyed_d = 1'b1;
          for (int s = 0; s < 2; s++) begin
            ii_d[s] = '0;
            jj_d[s] = '0;
          end
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          state_d = ST_K_RD;
        end
      end
      ST_P_RD1: begin
        ni_d            = ii_q[sel] + 8'd1;
        sbox_raddr[sel] = ni_d;
        state_d         = ST_P_RD2;
      end
      ST_P_RD2: begin
        a_d             = sbox_rd_q[sel];
        nj_d            = jj_q[sel] + sbox_rd_q[sel];
        sbox_raddr[sel] = nj_d;
        state_d         = ST_P_W1;
      end
      ST_P_W1: begin
        // Write new S[i] and read S[a+b] in the same cycle; forward the swap.
        b_d             = sbox_rd_q[sel];
        sbox_we[sel]    = 1'b1;
        sbox_waddr[sel] = ni_q;
        sbox_wdata[sel] = sbox_rd_q[sel];
        sbox_raddr[sel] = tidx;
        fwd_j_d         = (tidx == nj_q);
        fwd_i_d         = (tidx == ni_q);
        state_d         = ST_P_W2;
      end
      ST_P_W2: begin
        sbox_we[sel]    = 1'b1;
        sbox_waddr[sel] = nj_q;
        sbox_wdata[sel] = a_q;
        res_d           = data_q ^ kstream;
        ii_d[sel]       = ni_q;
        jj_d[sel]       = nj_q;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register frees up.
        if (out_free) begin
          out_valid_d = 1'b1;
          dout_d      = res_q;
          wkd_out_d   = was_q;
          lst_out_d   = last_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        ii_q[s] <= '0;
        jj_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
      for (int s = 0; s < 2; s++) begin
        ii_q[s] <= ii_d[s];
        jj_q[s] <= jj_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    data_q    <= data_d;
    last_q    <= last_d;
    was_q     <= was_d;
    res_q     <= res_d;
    k_q       <= k_d;
    ni_q      <= ni_d;
    nj_q      <= nj_d;
    a_q       <= a_d;
    b_q       <= b_d;
    fwd_i_q   <= fwd_i_d;
    fwd_j_q   <= fwd_j_d;
    dout_q    <= dout_d;
    wkd_out_q <= wkd_out_d;
    lst_out_q <= lst_out_d;
    for (int s = 0; s < 2; s++) begin
      acc_q[s]  <= acc_d[s];
      sk_q[s]   <= sk_d[s];
      kidx_q[s] <= kidx_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_key_lo_q  <= '0;
      enc_key_hi_q  <= '0;
      dec_key_lo_q  <= '0;
      dec_key_hi_q  <= '0;
      enc_key_len_q <= 5'd16;
      dec_key_len_q <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        drc4_pkg::REG_ENC_KEY_LO:  enc_key_lo_q  <= cfg_data_i;
        drc4_pkg::REG_ENC_KEY_HI:  enc_key_hi_q  <= cfg_data_i;
        drc4_pkg::REG_DEC_KEY_LO:  dec_key_lo_q  <= cfg_data_i;
        drc4_pkg::REG_DEC_KEY_HI:  dec_key_hi_q  <= cfg_data_i;
        drc4_pkg::REG_ENC_KEY_LEN: enc_key_len_q <= cfg_data_i[4:0];
        drc4_pkg::REG_DEC_KEY_LEN: dec_key_len_q <= cfg_data_i[4:0];
        default: begin
        end
      endcase
    end
  end

  `DRC4_ASSERT_NXT(a_keyed_sticky, keyed_q, keyed_q, "keyed flag dropped")
  `DRC4_ASSERT_IMP(a_prga_keyed, state_q == ST_P_RD1, keyed_q,
                   "keystream step started on an unkeyed block")
  `DRC4_ASSERT_IMP(a_one_stream, (state_q == ST_P_W1) || (state_q == ST_P_W2),
                   !(sbox_we[0] && sbox_we[1]), "byte item wrote both permutations")
  `DRC4_ASSERT_NXT(a_done_release, (state_q == ST_DONE) && out_free,
                   out_valid_q && (state_q == ST_IDLE), "finished item not handed out")

endmodule
`default_nettype wire

// ===== dv/rc4_pair_checker.sv =====
// Checker for the dual RC4 cipher: mirrors both keystream generators and compares every result.
module rc4_pair_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  drc4_pkg::cfg_idx_t cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  drc4_pkg::mode_t    mode_i,
  input  drc4_pkg::byte_t    data_in_i,
  input  logic               last_in_message_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  drc4_pkg::byte_t    data_out_i,
  input  logic               was_keyed_i,
  input  logic               last_out_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  localparam int ENC_STREAM = 0;
  localparam int DEC_STREAM = 1;

  typedef struct packed {
    drc4_pkg::byte_t data;
    logic            keyed;
    logic            last;
  } cipher_result_t;

  drc4_pkg::byte_t    sbox [2][256];
  drc4_pkg::byte_t    ptr_i [2];
  drc4_pkg::byte_t    ptr_j [2];
  logic [63:0]        key_lo [2];
  logic [63:0]        key_hi [2];
  drc4_pkg::key_len_t key_len [2];
  logic               keyed;
  cipher_result_t     awaited_results_q [$];

  // Zero acts as one byte, anything past the key width saturates.
  function automatic int used_key_bytes(input drc4_pkg::key_len_t len);
    if (len == 5'd0) return 1;
    if (int'(len) > drc4_pkg::MAX_KEY_BYTES) return drc4_pkg::MAX_KEY_BYTES;
    return int'(len);
  endfunction

  task automatic rc4_schedule(input int s);
    logic [127:0]    key;
    int              n;
    int              k;
    drc4_pkg::byte_t acc;
    drc4_pkg::byte_t tmp;
    key = {key_hi[s], key_lo[s]};
    n   = used_key_bytes(key_len[s]);
    for (k = 0; k < 256; k++) sbox[s][k] = drc4_pkg::byte_t'(k);
    acc = '0;
    for (k = 0; k < 256; k++) begin
      acc          = acc + sbox[s][k] + key[8*(k % n) +: 8];
      tmp          = sbox[s][k];
      sbox[s][k]   = sbox[s][acc];
      sbox[s][acc] = tmp;
    end
    ptr_i[s] = '0;
    ptr_j[s] = '0;
  endtask

  function automatic drc4_pkg::byte_t rc4_keystream_byte(input int s);
    drc4_pkg::byte_t tmp;
    drc4_pkg::byte_t sum;
    ptr_i[s]             = ptr_i[s] + 8'd1;
    ptr_j[s]             = ptr_j[s] + sbox[s][ptr_i[s]];
    tmp                  = sbox[s][ptr_i[s]];
    sbox[s][ptr_i[s]]    = sbox[s][ptr_j[s]];
    sbox[s][ptr_j[s]]    = tmp;
    sum                  = sbox[s][ptr_i[s]] + sbox[s][ptr_j[s]];
    return sbox[s][sum];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cipher_result_t want;
    int             s;
    if (!rst_ni) begin
      for (s = 0; s < 2; s++) begin
        key_lo[s]  = '0;
        key_hi[s]  = '0;
        key_len[s] = 5'd16;
        ptr_i[s]   = '0;
        ptr_j[s]   = '0;
      end
      keyed = 1'b0;
      awaited_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          drc4_pkg::REG_ENC_KEY_LO:  key_lo[ENC_STREAM]  = cfg_data_i;
          drc4_pkg::REG_ENC_KEY_HI:  key_hi[ENC_STREAM]  = cfg_data_i;
          drc4_pkg::REG_DEC_KEY_LO:  key_lo[DEC_STREAM]  = cfg_data_i;
          drc4_pkg::REG_DEC_KEY_HI:  key_hi[DEC_STREAM]  = cfg_data_i;
          drc4_pkg::REG_ENC_KEY_LEN: key_len[ENC_STREAM] = cfg_data_i[4:0];
          drc4_pkg::REG_DEC_KEY_LEN: key_len[DEC_STREAM] = cfg_data_i[4:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (awaited_results_q.size() == 0) begin
          $error("result item with none expected: data_out %0h", data_out_i);
          fail_count_o++;
        end else begin
          want = awaited_results_q.pop_front();
          if (data_out_i !== want.data) begin
            $error("data_out mismatch: expected %0h, actual %0h", want.data, data_out_i);
            fail_count_o++;
          end
          if (was_keyed_i !== want.keyed) begin
            $error("was_keyed mismatch: expected %0b, actual %0b", want.keyed, was_keyed_i);
            fail_count_o++;
          end
          if (last_out_i !== want.last) begin
            $error("last_out mismatch: expected %0b, actual %0b", want.last, last_out_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        want.keyed = keyed;
        want.last  = last_in_message_i;
        want.data  = '0;
        case (mode_i)
          drc4_pkg::MODE_ENC, drc4_pkg::MODE_DEC: begin
            s = (mode_i == drc4_pkg::MODE_ENC) ? ENC_STREAM : DEC_STREAM;
            if (keyed) begin
              want.data = data_in_i ^ rc4_keystream_byte(s);
            end else begin
              want.data = data_in_i;
            end
          end
          drc4_pkg::MODE_REKEY: begin
            rc4_schedule(ENC_STREAM);
            rc4_schedule(DEC_STREAM);
            keyed = 1'b1;
          end
          // unused mode: zero data, no state moves
          default: ;
        endcase
        awaited_results_q.push_back(want);
      end

      pending_o = awaited_results_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: drives the dual RC4 cipher with directed and random items and gives the verdict.
module tb;

  localparam int                 ITEM_TARGET   = 800;
  localparam int unsigned        CYCLE_LIMIT   = 5_000_000;
  localparam int                 SETTLE_CYCLES = 1300;
  localparam drc4_pkg::mode_t    MODE_IGNORED  = 2'd3;
  localparam drc4_pkg::cfg_idx_t REG_SPARE_6   = 3'd6;
  localparam drc4_pkg::cfg_idx_t REG_SPARE_7   = 3'd7;
  localparam drc4_pkg::cfg_idx_t REG_ORDER [8] = '{
    drc4_pkg::REG_ENC_KEY_LO, drc4_pkg::REG_ENC_KEY_HI, drc4_pkg::REG_DEC_KEY_LO,
    drc4_pkg::REG_DEC_KEY_HI, drc4_pkg::REG_ENC_KEY_LEN, drc4_pkg::REG_DEC_KEY_LEN,
    REG_SPARE_6, REG_SPARE_7};

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  drc4_pkg::cfg_idx_t cfg_index;
  logic [63:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  drc4_pkg::mode_t    in_mode;
  drc4_pkg::byte_t    in_data;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  drc4_pkg::byte_t    out_data;
  logic               out_keyed;
  logic               out_last;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        cycle_count = 0;
  int                 items_sent;
  bit                 quiet;
  logic [63:0]        reg_plan [8];

  dual_rc4_stream_cipher_top u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (in_mode),
    .data_in_i        (in_data),
    .last_in_message_i(in_last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .data_out_o       (out_data),
    .was_keyed_o      (out_keyed),
    .last_out_o       (out_last)
  );

  rc4_pair_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (in_mode),
    .data_in_i        (in_data),
    .last_in_message_i(in_last),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .data_out_i       (out_data),
    .was_keyed_i      (out_keyed),
    .last_out_i       (out_last),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none at all in quiet phases.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_len();
    case ($urandom_range(0, 11))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'd16;
      3:       return 64'($urandom_range(17, 31));
      4:       return {$urandom, $urandom};
      default: return 64'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic drc4_pkg::byte_t rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return drc4_pkg::byte_t'($urandom);
    endcase
  endfunction

  task automatic send_item(input drc4_pkg::mode_t m, input drc4_pkg::byte_t d, input logic l);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_data  <= d;
    in_last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (m != MODE_IGNORED) items_sent++;
  endtask

  // Hold off input until every result is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input drc4_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the registers picked by sel from reg_plan; call only when idle.
  task automatic apply_config(input bit [7:0] sel);
    int r;
    for (r = 0; r < 8; r++) begin
      if (sel[r]) write_reg(REG_ORDER[r], reg_plan[r]);
    end
    if (sel != 0) begin
      cfg_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  initial begin : stall_gen
    int unsigned r;
    int unsigned len;
    logic        val;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        val = 1'b0;
        len = $urandom_range(20, 200);
      end else if (r < 80) begin
        val = 1'b0;
        len = $urandom_range(1, 6);
      end else if (r < 96) begin
        val = 1'b1;
        len = $urandom_range(1, 4);
      end else begin
        val = 1'b1;
        len = $urandom_range(20, 150);
      end
      @(negedge clk);
      out_stall <= val;
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    int      n;
    int      phase_len;
    int      r;
    bit [7:0] sel;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = drc4_pkg::REG_ENC_KEY_LO;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_mode    = drc4_pkg::MODE_ENC;
    in_data    = '0;
    in_last    = 1'b0;
    quiet      = 1'b0;
    items_sent = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Not keyed yet: bytes pass through, the unused mode returns zero.
    send_item(drc4_pkg::MODE_ENC, 8'h00, 1'b0);
    send_item(drc4_pkg::MODE_DEC, 8'hFF, 1'b1);
    send_item(MODE_IGNORED, 8'hA5, 1'b1);
    // Rekey with the reset keys: all zero, full length.
    send_item(drc4_pkg::MODE_REKEY, 8'hFF, 1'b0);
    send_item(drc4_pkg::MODE_ENC, 8'h00, 1'b0);
    send_item(drc4_pkg::MODE_ENC, 8'hFF, 1'b1);
    send_item(drc4_pkg::MODE_DEC, 8'h5A, 1'b0);
    send_item(MODE_IGNORED, 8'hFF, 1'b0);

    // All-ones keys, full length; spare indexes must leave the keys alone.
    drain();
    reg_plan[drc4_pkg::REG_ENC_KEY_LO]  = '1;
    reg_plan[drc4_pkg::REG_ENC_KEY_HI]  = '1;
    reg_plan[drc4_pkg::REG_DEC_KEY_LO]  = '1;
    reg_plan[drc4_pkg::REG_DEC_KEY_HI]  = '1;
    reg_plan[drc4_pkg::REG_ENC_KEY_LEN] = 64'd16;
    reg_plan[drc4_pkg::REG_DEC_KEY_LEN] = 64'd16;
    reg_plan[REG_SPARE_6]               = {$urandom, $urandom};
    reg_plan[REG_SPARE_7]               = {$urandom, $urandom};
    apply_config(8'hFF);
    send_item(drc4_pkg::MODE_REKEY, 8'h00, 1'b1);
    send_item(drc4_pkg::MODE_ENC, 8'hFF, 1'b0);
    send_item(drc4_pkg::MODE_DEC, 8'h00, 1'b1);

    // Shortest key, and a zero length that acts as one byte.
    drain();
    reg_plan[drc4_pkg::REG_ENC_KEY_LO]  = {$urandom, $urandom};
    reg_plan[drc4_pkg::REG_DEC_KEY_LO]  = {$urandom, $urandom};
    reg_plan[drc4_pkg::REG_ENC_KEY_LEN] = 64'd1;
    reg_plan[drc4_pkg::REG_DEC_KEY_LEN] = 64'd0;
    apply_config(8'h35);
    send_item(drc4_pkg::MODE_REKEY, rand_byte(), 1'b0);
    send_item(drc4_pkg::MODE_ENC, rand_byte(), 1'b0);
    send_item(drc4_pkg::MODE_DEC, rand_byte(), 1'b1);

    // Lengths past the key width saturate; rekey again mid-stream.
    drain();
    reg_plan[drc4_pkg::REG_ENC_KEY_HI]  = {$urandom, $urandom};
    reg_plan[drc4_pkg::REG_DEC_KEY_HI]  = {$urandom, $urandom};
    reg_plan[drc4_pkg::REG_ENC_KEY_LEN] = 64'd17;
    reg_plan[drc4_pkg::REG_DEC_KEY_LEN] = 64'd31;
    apply_config(8'h3A);
    send_item(drc4_pkg::MODE_REKEY, rand_byte(), 1'b1);
    send_item(drc4_pkg::MODE_ENC, rand_byte(), 1'b0);
    send_item(drc4_pkg::MODE_DEC, rand_byte(), 1'b0);
    send_item(drc4_pkg::MODE_REKEY, rand_byte(), 1'b0);
    send_item(drc4_pkg::MODE_ENC, rand_byte(), 1'b1);

    // Random phases: sometimes new settings, usually a rekey, then a message stream.
    while (items_sent < ITEM_TARGET) begin
      drain();
      quiet = ($urandom_range(0, 4) == 0);
      sel   = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(1, 63));
      if ($urandom_range(0, 15) == 0) sel[7:6] = 2'($urandom);
      reg_plan[drc4_pkg::REG_ENC_KEY_LO]  = rand_key();
      reg_plan[drc4_pkg::REG_ENC_KEY_HI]  = rand_key();
      reg_plan[drc4_pkg::REG_DEC_KEY_LO]  = rand_key();
      reg_plan[drc4_pkg::REG_DEC_KEY_HI]  = rand_key();
      reg_plan[drc4_pkg::REG_ENC_KEY_LEN] = rand_len();
      reg_plan[drc4_pkg::REG_DEC_KEY_LEN] = rand_len();
      reg_plan[REG_SPARE_6]               = {$urandom, $urandom};
      reg_plan[REG_SPARE_7]               = {$urandom, $urandom};
      apply_config(sel);
      if ($urandom_range(0, 9) != 0) begin
        send_item(drc4_pkg::MODE_REKEY, rand_byte(), 1'($urandom));
      end
      phase_len = $urandom_range(8, 40);
      for (n = 0; n < phase_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 2) drain();
        if (r < 3) begin
          send_item(drc4_pkg::MODE_REKEY, rand_byte(), 1'($urandom));
        end else if (r < 6) begin
          send_item(MODE_IGNORED, rand_byte(), 1'($urandom));
        end else if (r < 53) begin
          send_item(drc4_pkg::MODE_ENC, rand_byte(), ($urandom_range(0, 7) == 0));
        end else begin
          send_item(drc4_pkg::MODE_DEC, rand_byte(), ($urandom_range(0, 7) == 0));
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/drc4_pkg.sv
sv/dual_rc4_stream_cipher_top.sv
dv/rc4_pair_checker.sv
dv/tb.sv
